[sv/wfs_pkg.sv]
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared types and constants of the 802.11 frame source and SSID extractor.
// ----------------------------------------------------------------------------
package wfs_pkg;

	// frame control decoding
	localparam logic [15:0] FC_TYPE_MASK = 16'h000C;
	localparam logic [15:0] FC_SUB_MASK  = 16'h00F0;

	localparam logic [1:0] TYPE_MGMT = 2'd0;
	localparam logic [1:0] TYPE_CTRL = 2'd1;
	localparam logic [1:0] TYPE_DATA = 2'd2;

	localparam logic [3:0] SUB_ASSOC_REQ   = 4'd0;
	localparam logic [3:0] SUB_REASSOC_REQ = 4'd2;
	localparam logic [3:0] SUB_PROBE_REQ   = 4'd4;
	localparam logic [3:0] SUB_DISASSOC    = 4'd10;
	localparam logic [3:0] SUB_DEAUTH      = 4'd12;
	localparam logic [3:0] SUB_CF_END      = 4'd14;
	localparam logic [3:0] SUB_CTRL_LO     = 4'd8;
	localparam logic [3:0] SUB_CTRL_HI     = 4'd11;
	localparam logic [3:0] SUB_CTRL_TOP    = 4'd13;

	// byte offsets
	localparam int IE_START       = 24;
	localparam int ADDR_OFF_STD   = 10;
	localparam int ADDR_OFF_CFEND = 4;
	localparam int ADDR_BYTES     = 6;

	localparam logic [7:0] DOT_CHAR      = 8'h2E;
	localparam logic [7:0] PRINT_LO      = 8'h20;
	localparam logic [7:0] PRINT_HI      = 8'h7E;
	localparam logic [7:0] IE_ID_SSID    = 8'h00;

	// configuration registers
	localparam logic [7:0] CFG_MIN_RSSI  = 8'd0;
	localparam logic [7:0] CFG_MGMT_ONLY = 8'd1;
	localparam logic signed [7:0] RSSI_RESET = -8'sd100;

	// character count field, wide enough for the largest SSID
	localparam int NCHARS_W = 6;

	// result queue of the back end
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 3;

	typedef enum logic [2:0] {
		KIND_IGNORED = 3'd0,
		KIND_ASSOC   = 3'd1,
		KIND_PROBE   = 3'd2,
		KIND_DEAUTH  = 3'd3,
		KIND_CONTROL = 3'd4,
		KIND_DATA    = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		IE_AWAIT_ID       = 2'd0,
		IE_AWAIT_LEN      = 2'd1,
		IE_AWAIT_SSID_LEN = 2'd2
	} ie_phase_t;

	typedef enum logic [1:0] {
		SSID_SEARCH = 2'd0,
		SSID_FOUND  = 2'd1,
		SSID_HIDDEN = 2'd2
	} ssid_state_t;

	typedef struct packed {
		kind_t                kind;
		logic [47:0]          addr;
		logic                 valid;
		logic [NCHARS_W-1:0]  nchars;
	} summary_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic wr_bank;
		logic rd_bank;
	} q_stat_t;

	typedef struct packed {
		kind_t       kind;
		logic [47:0] addr;
		logic        valid;
		logic [7:0]  ch;
		logic        is_char;
		logic        last;
	} result_t;

endpackage

[sv/wifi_frame_source_and_ssid_extractor.sv]
// ----------------------------------------------------------------------------
// wifi_frame_source_and_ssid_extractor
// 802.11 frame classifier with source address capture and SSID extraction.
// ----------------------------------------------------------------------------
// usage
//   input: one frame byte per beat on push/full, with first_of_frame,
//   last_of_frame and signal_level (sampled on the first byte). a byte is
//   taken every cycle; full rises only while two finished frames are still
//   waiting to be played out, since each owns one bank of the SSID memory.
//   results: empty/pop queue. per frame one header beat, then up to
//   SSID_BYTES character beats, last_result on the final one. the header
//   passes the summary queue and the registered SSID memory read that feeds
//   a four-entry result queue; then one result per cycle while it has room.
//   configuration: cfg_valid/cfg_ready (always ready), index 0 minimum rssi,
//   index 1 management-only; write only while the block is idle.
//   reset: rssi threshold -100, management-only off, all queues empty; the
//   SSID memory is not cleared (only entries written by the frame are read).
//   a stalled receiver fills the result queue, then the summary queue, and
//   finally raises full; nothing is dropped.
// ----------------------------------------------------------------------------
module wifi_frame_source_and_ssid_extractor
	import wfs_pkg::*;
#(
	parameter int SSID_BYTES      = 32,
	parameter int MAX_FRAME_BYTES = 4095
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        frame_byte,
	input  logic              first_of_frame,
	input  logic              last_of_frame,
	input  logic signed [7:0] signal_level,
	output logic              empty,
	input  logic              pop,
	output logic [2:0]        frame_kind,
	output logic [47:0]       source_address,
	output logic              address_valid,
	output logic [7:0]        ssid_char,
	output logic              is_ssid_char,
	output logic              last_result
);

	localparam int IDX_W = (SSID_BYTES > 1) ? $clog2(SSID_BYTES) : 1;

	q_stat_t          q_stat;
	logic             q_push, q_pop;
	summary_t         q_wdata, q_rdata;
	logic             ram_we, ram_re;
	logic [IDX_W:0]   ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;
	result_t          res;

	assign cfg_ready = 1'b1;
	assign full      = q_stat.full;

	wfs_front #(
		.SSID_BYTES      (SSID_BYTES),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.frame_byte     (frame_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.signal_level   (signal_level),
		.q_stat         (q_stat),
		.q_push         (q_push),
		.q_data         (q_wdata),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata)
	);

	wfs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	wfs_ram #(
		.WIDTH (8),
		.DEPTH (2 << IDX_W)
	) u_ssid_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wfs_back #(
		.SSID_BYTES (SSID_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_rdata),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign frame_kind     = res.kind;
	assign source_address = res.addr;
	assign address_valid  = res.valid;
	assign ssid_char      = res.ch;
	assign is_ssid_char   = res.is_char;
	assign last_result    = res.last;

	// characters only ever follow a probe request header
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && is_ssid_char |-> frame_kind == KIND_PROBE)
		else $error("ssid character on a non-probe frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !address_valid |-> source_address == 48'd0)
		else $error("address shown without address_valid");

endmodule

[sv/wfs_ram.sv]
// ----------------------------------------------------------------------------
// wfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/wfs_front.sv]
// ----------------------------------------------------------------------------
// wfs_front
// Byte parser: frame control decode, address capture, SSID element walk.
// ----------------------------------------------------------------------------
module wfs_front
	import wfs_pkg::*;
#(
	parameter int SSID_BYTES      = 32,
	parameter int MAX_FRAME_BYTES = 4095
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [7:0]                cfg_index,
	input  logic [7:0]                cfg_data,
	input  logic                      push,
	input  logic [7:0]                frame_byte,
	input  logic                      first_of_frame,
	input  logic                      last_of_frame,
	input  logic signed [7:0]         signal_level,
	input  q_stat_t                   q_stat,
	output logic                      q_push,
	output summary_t                  q_data,
	output logic                      ram_we,
	output logic [IDX_W:0]            ram_waddr,
	output logic [7:0]                ram_wdata
);

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int IDX_W = (SSID_BYTES > 1) ? $clog2(SSID_BYTES) : 1;
	localparam int LEN_W = $clog2(SSID_BYTES + 1);
	localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_FRAME_BYTES);
	localparam logic [POS_W-1:0] IE_POS    = POS_W'(IE_START);
	localparam logic [7:0]       SSID_MAX8 = 8'(SSID_BYTES);

	logic [POS_W-1:0]   pos_q, nep_q, start_q;
	logic [15:0]        fc_q;
	logic               sp_q;
	logic [47:0]        addr_q;
	ie_phase_t          phase_q;
	ssid_state_t        state_q;
	logic [LEN_W-1:0]   len_q;
	logic signed [7:0]  min_rssi_q;
	logic               mgmt_only_q;

	logic               accept, take, probe;
	logic [POS_W-1:0]   e_pos, e_nep, e_start, n_pos, n_nep, n_start, off, rel, k;
	logic [15:0]        e_fc, n_fc;
	logic               e_sp;
	logic [47:0]        e_addr, n_addr;
	ie_phase_t          e_phase, n_phase;
	ssid_state_t        e_state, n_state;
	logic [LEN_W-1:0]   e_len, n_len;
	logic [1:0]         fc_type;
	logic [3:0]         fc_sub;
	logic [POS_W+1:0]   nep_sum;
	logic [POS_W:0]     ssid_end;
	kind_t              kind;
	logic               addr_ok;

	assign accept = push && !q_stat.full;

	// state as seen by this byte, after a first marker restarts the frame
	always_comb begin
		e_pos   = first_of_frame ? '0 : pos_q;
		e_fc    = first_of_frame ? '0 : fc_q;
		e_sp    = first_of_frame ? (signal_level >= min_rssi_q) : sp_q;
		e_addr  = first_of_frame ? '0 : addr_q;
		e_nep   = first_of_frame ? IE_POS : nep_q;
		e_phase = first_of_frame ? IE_AWAIT_ID : phase_q;
		e_state = first_of_frame ? SSID_SEARCH : state_q;
		e_start = first_of_frame ? '0 : start_q;
		e_len   = first_of_frame ? '0 : len_q;
	end

	// next frame state
	always_comb begin
		take     = e_pos < MAX_POS;
		n_pos    = take ? e_pos + 1'b1 : e_pos;
		n_fc     = e_fc;
		n_addr   = e_addr;
		n_nep    = e_nep;
		n_phase  = e_phase;
		n_state  = e_state;
		n_start  = e_start;
		n_len    = e_len;
		ram_we   = 1'b0;
		k        = e_pos - e_start;
		nep_sum  = (POS_W+2)'(e_nep) + (POS_W+2)'(frame_byte) + (POS_W+2)'(2);
		ssid_end = (POS_W+1)'(e_start) + (POS_W+1)'(e_len);

		if (take && e_pos == '0) begin
			n_fc = {e_fc[15:8], frame_byte};
		end else if (take && e_pos == POS_W'(1)) begin
			n_fc = {frame_byte, e_fc[7:0]};
		end

		fc_type = 2'((n_fc & FC_TYPE_MASK) >> 2);
		fc_sub  = 4'((n_fc & FC_SUB_MASK) >> 4);
		off     = (fc_type == TYPE_CTRL && fc_sub >= SUB_CF_END) ? POS_W'(ADDR_OFF_CFEND)
			: POS_W'(ADDR_OFF_STD);
		rel     = e_pos - off;
		probe   = fc_type == TYPE_MGMT && fc_sub == SUB_PROBE_REQ;

		if (take && e_pos >= off && rel < POS_W'(ADDR_BYTES)) begin
			n_addr[{rel[2:0], 3'b000} +: 8] = frame_byte;
		end

		if (take && probe) begin
			unique case (e_state)
				SSID_SEARCH: begin
					unique case (e_phase)
						IE_AWAIT_ID: begin
							if (e_pos == e_nep) begin
								n_phase = (frame_byte == IE_ID_SSID) ? IE_AWAIT_SSID_LEN
									: IE_AWAIT_LEN;
							end
						end
						IE_AWAIT_LEN: begin
							n_nep   = (nep_sum > (POS_W+2)'(MAX_POS)) ? MAX_POS
								: nep_sum[POS_W-1:0];
							n_phase = IE_AWAIT_ID;
						end
						IE_AWAIT_SSID_LEN: begin
							n_phase = IE_AWAIT_ID;
							if (frame_byte == 8'd0) begin
								n_state = SSID_HIDDEN;
							end else begin
								n_len   = (frame_byte > SSID_MAX8) ? LEN_W'(SSID_BYTES)
									: frame_byte[LEN_W-1:0];
								n_start = e_pos + 1'b1;
								n_state = SSID_FOUND;
							end
						end
						default: n_phase = IE_AWAIT_ID;
					endcase
				end
				SSID_FOUND: begin
					if (e_pos >= e_start && {1'b0, e_pos} < ssid_end) begin
						ram_we = accept;
					end
				end
				SSID_HIDDEN: ;
				default: n_state = SSID_SEARCH;
			endcase
		end
	end

	assign ram_waddr = {q_stat.wr_bank, k[IDX_W-1:0]};
	assign ram_wdata = (frame_byte >= PRINT_LO && frame_byte <= PRINT_HI) ? frame_byte
		: DOT_CHAR;

	// end-of-frame classification
	always_comb begin
		kind = KIND_IGNORED;
		if (e_sp) begin
			priority if (fc_type == TYPE_MGMT) begin
				priority if (fc_sub == SUB_ASSOC_REQ || fc_sub == SUB_REASSOC_REQ) kind = KIND_ASSOC;
				else if (fc_sub == SUB_PROBE_REQ) kind = KIND_PROBE;
				else if (fc_sub == SUB_DISASSOC || fc_sub == SUB_DEAUTH) kind = KIND_DEAUTH;
				else kind = KIND_IGNORED;
			end else if (mgmt_only_q) begin
				kind = KIND_IGNORED;
			end else if (fc_type == TYPE_CTRL) begin
				if ((fc_sub >= SUB_CTRL_LO && fc_sub <= SUB_CTRL_HI) || fc_sub >= SUB_CTRL_TOP) begin
					kind = KIND_CONTROL;
				end
			end else if (fc_type == TYPE_DATA) begin
				kind = KIND_DATA;
			end else begin
				kind = KIND_IGNORED;
			end
		end
		addr_ok = kind != KIND_IGNORED
			&& (POS_W+1)'(n_pos) >= (POS_W+1)'(off) + (POS_W+1)'(ADDR_BYTES);
		q_data.kind   = kind;
		q_data.valid  = addr_ok;
		q_data.addr   = addr_ok ? n_addr : '0;
		q_data.nchars = '0;
		if (kind == KIND_PROBE && n_state == SSID_FOUND
				&& (POS_W+1)'(n_start) + (POS_W+1)'(n_len) <= (POS_W+1)'(n_pos)) begin
			q_data.nchars = NCHARS_W'(n_len);
		end
	end

	assign q_push = accept && last_of_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fc_q    <= '0;
			sp_q    <= 1'b0;
			addr_q  <= '0;
			nep_q   <= IE_POS;
			phase_q <= IE_AWAIT_ID;
			state_q <= SSID_SEARCH;
			start_q <= '0;
			len_q   <= '0;
		end else if (accept) begin
			if (last_of_frame) begin
				pos_q   <= '0;
				fc_q    <= '0;
				sp_q    <= 1'b0;
				addr_q  <= '0;
				nep_q   <= IE_POS;
				phase_q <= IE_AWAIT_ID;
				state_q <= SSID_SEARCH;
				start_q <= '0;
				len_q   <= '0;
			end else begin
				pos_q   <= n_pos;
				fc_q    <= n_fc;
				sp_q    <= e_sp;
				addr_q  <= n_addr;
				nep_q   <= n_nep;
				phase_q <= n_phase;
				state_q <= n_state;
				start_q <= n_start;
				len_q   <= n_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rssi_q  <= RSSI_RESET;
			mgmt_only_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MIN_RSSI) begin
				min_rssi_q <= cfg_data;
			end else if (cfg_index == CFG_MGMT_ONLY) begin
				mgmt_only_q <= cfg_data[0];
			end
		end
	end

endmodule

[sv/wfs_queue.sv]
// ----------------------------------------------------------------------------
// wfs_queue
// Two-entry queue of frame summaries; the slot number also picks the SSID bank.
// ----------------------------------------------------------------------------
module wfs_queue
	import wfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  summary_t wdata,
	input  logic     pop,
	output summary_t rdata,
	output q_stat_t  stat
);

	summary_t   slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign stat.empty   = cnt_q == 2'd0;
	assign stat.full    = cnt_q == 2'd2;
	assign stat.wr_bank = wr_ptr_q;
	assign stat.rd_bank = rd_ptr_q;
	assign rdata        = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// the front only accepts bytes while a slot and its bank are free
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !stat.full)
		else $error("summary pushed into a full queue");

endmodule

[sv/wfs_back.sv]
// ----------------------------------------------------------------------------
// wfs_back
// Result sequencer: header then SSID characters per frame, into a result queue.
// ----------------------------------------------------------------------------
module wfs_back
	import wfs_pkg::*;
#(
	parameter int SSID_BYTES = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  summary_t        head,
	input  q_stat_t         q_stat,
	output logic            q_pop,
	output logic            ram_re,
	output logic [IDX_W:0]  ram_raddr,
	input  logic [7:0]      ram_rdata,
	input  logic            pop,
	output logic            empty,
	output result_t         res
);

	localparam int IDX_W = (SSID_BYTES > 1) ? $clog2(SSID_BYTES) : 1;

	logic [NCHARS_W-1:0]  k_q, km1;
	logic                 issue, is_last;
	logic                 s1_valid_s1, s1_is_char_s1, s1_last_s1, s1_addr_ok_s1;
	kind_t                s1_kind_s1;
	logic [47:0]          s1_addr_s1;
	result_t              out_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_CNT_W-1:0] cnt_q;
	logic                 out_pop;
	result_t              push_data;

	// issue only when the result queue has room for everything in flight
	assign issue   = !q_stat.empty
		&& (cnt_q + OUT_CNT_W'(s1_valid_s1)) < OUT_CNT_W'(OUT_DEPTH);
	assign is_last = k_q == head.nchars;
	assign q_pop   = issue && is_last;
	assign km1     = k_q - 1'b1;
	assign ram_re  = issue;
	assign ram_raddr = {q_stat.rd_bank, km1[IDX_W-1:0]};

	assign out_pop = pop && !empty;
	assign empty   = cnt_q == '0;
	assign res     = out_q[rd_ptr_q];

	always_comb begin
		push_data.kind    = s1_kind_s1;
		push_data.addr    = s1_addr_s1;
		push_data.valid   = s1_addr_ok_s1;
		push_data.ch      = s1_is_char_s1 ? ram_rdata : 8'd0;
		push_data.is_char = s1_is_char_s1;
		push_data.last    = s1_last_s1;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_kind_s1    <= head.kind;
			s1_addr_s1    <= head.addr;
			s1_addr_ok_s1 <= head.valid;
			s1_is_char_s1 <= k_q != '0;
			s1_last_s1    <= is_last;
		end
		if (s1_valid_s1) begin
			out_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			s1_valid_s1 <= 1'b0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
		end else begin
			s1_valid_s1 <= issue;
			if (issue) begin
				k_q <= is_last ? '0 : k_q + 1'b1;
			end
			if (s1_valid_s1) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + OUT_CNT_W'(s1_valid_s1) - OUT_CNT_W'(out_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("result queue overflow");

	// a beat in flight always has a free slot waiting for it
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 |-> cnt_q < OUT_CNT_W'(OUT_DEPTH))
		else $error("read in flight without room in result queue");

endmodule

[tb/wifi_frame_source_and_ssid_extractor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi_frame_source_and_ssid_extractor_test
// Feeds 802.11 frames byte by byte and checks every result beat (frame kind,
// source address, SSID characters) against a cycle-free parser kept here.
// Directed frames cover every kind, short, hidden, clipped, truncated,
// unmarked, restarted and overlong frames; random frames follow, mostly probe
// requests with random elements, under several threshold/mode settings.
// ----------------------------------------------------------------------------
module wifi_frame_source_and_ssid_extractor_test;
	import wfs_pkg::*;

	localparam int SSID_MAX     = 32;
	localparam int MAX_FRAME    = 4095;
	localparam int SETTLE       = 8;
	localparam int STALL_LIMIT  = 400;
	localparam int RANDOM_BYTES = 370;
	localparam int RANDOM_BEATS = 48;
	localparam int CALM_AFTER   = 290;
	localparam int PLAN_ROWS    = 28;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [7:0]        fc0;
		int                nbytes;
		logic signed [7:0] level;
		bit                marked;
		int                lead;
		logic signed [7:0] rssi;
		bit                mgmt;
		int                ssid;
		int                others;
		bit                pin;
		kind_t             kind;
	} frame_row_t;

	// fc0, bytes, level, first marker, abandoned lead, threshold, mgmt only,
	// ssid length (-1 none), other elements, kind typed in, kind
	localparam frame_row_t FRAME_PLAN [PLAN_ROWS] = '{
		'{8'h00, 30, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_ASSOC},
		'{8'h20, 28, -8'sd100, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_ASSOC},
		'{8'h40, 0, -8'sd40, 1'b1, 0, -8'sd100, 1'b0, 5, 0, 1'b1, KIND_PROBE},
		'{8'h40, 0, -8'sd40, 1'b1, 0, -8'sd100, 1'b0, 0, 0, 1'b1, KIND_PROBE},
		'{8'h41, 0, -8'sd40, 1'b1, 0, -8'sd100, 1'b0, 40, 1, 1'b1, KIND_PROBE},
		'{8'h40, 30, -8'sd40, 1'b1, 0, -8'sd100, 1'b0, 10, 0, 1'b1, KIND_PROBE},
		'{8'h42, 0, -8'sd40, 1'b1, 0, -8'sd100, 1'b0, 3, 2, 1'b1, KIND_PROBE},
		'{8'h43, 0, -8'sd40, 1'b1, 0, -8'sd100, 1'b0, -1, 1, 1'b1, KIND_PROBE},
		'{8'hA0, 24, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_DEAUTH},
		'{8'hC0, 26, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_DEAUTH},
		'{8'h80, 36, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_IGNORED},
		'{8'h84, 20, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_CONTROL},
		'{8'hE4, 10, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_CONTROL},
		'{8'hF4, 9, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_CONTROL},
		'{8'hC4, 16, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_IGNORED},
		'{8'h08, 40, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_DATA},
		'{8'h0C, 20, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_IGNORED},
		'{8'h08, 12, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_DATA},
		'{8'h88, 1, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_DATA},
		'{8'h08, 20, 8'sd0, 1'b0, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_IGNORED},
		'{8'h00, 24, -8'sd101, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_IGNORED},
		'{8'h00, 24, 8'sh80, 1'b1, 0, 8'sh80, 1'b0, -1, 0, 1'b1, KIND_ASSOC},
		'{8'h08, 24, 8'sd127, 1'b1, 0, 8'sd127, 1'b0, -1, 0, 1'b1, KIND_DATA},
		'{8'h08, 24, 8'sd126, 1'b1, 0, 8'sd127, 1'b0, -1, 0, 1'b1, KIND_IGNORED},
		'{8'h08, 30, 8'sd0, 1'b1, 0, 8'sh80, 1'b1, -1, 0, 1'b1, KIND_IGNORED},
		'{8'h40, 0, 8'sd0, 1'b1, 0, 8'sh80, 1'b1, 8, 0, 1'b1, KIND_PROBE},
		'{8'hA0, 30, 8'sd0, 1'b1, 15, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_DEAUTH},
		'{8'h08, 4100, 8'sd0, 1'b1, 0, -8'sd100, 1'b0, -1, 0, 1'b1, KIND_DATA}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [7:0]        cfg_index = CFG_MIN_RSSI;
	logic [7:0]        cfg_data = '0;
	logic              push = 1'b0;
	logic              full;
	logic [7:0]        frame_byte = '0;
	logic              first_of_frame = 1'b0;
	logic              last_of_frame = 1'b0;
	logic signed [7:0] signal_level = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [2:0]        frame_kind;
	logic [47:0]       source_address;
	logic              address_valid;
	logic [7:0]        ssid_char;
	logic              is_ssid_char;
	logic              last_result;

	wifi_frame_source_and_ssid_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.frame_byte(frame_byte),
		.first_of_frame(first_of_frame),
		.last_of_frame(last_of_frame),
		.signal_level(signal_level),
		.empty(empty),
		.pop(pop),
		.frame_kind(frame_kind),
		.source_address(source_address),
		.address_valid(address_valid),
		.ssid_char(ssid_char),
		.is_ssid_char(is_ssid_char),
		.last_result(last_result)
	);

	always #6 clk = ~clk;

	// parser state mirrored from the block
	logic signed [7:0] rssi_floor;
	bit                mgmt_only_mode;
	logic [11:0]       pos;
	logic [15:0]       fcw;
	logic              sig_ok;
	logic [47:0]       src_addr;
	logic [11:0]       next_ie;
	ie_phase_t         ie_phase;
	logic [7:0]        ie_len;
	ssid_state_t       ssid_st;
	logic [11:0]       ssid_at;
	logic [5:0]        ssid_cnt;
	logic [7:0]        ssid_mem [SSID_MAX];

	result_t expected_beats[$];
	int      mismatches = 0;
	int      beats_checked = 0;
	int      beats_predicted = 0;
	int      bytes_sent = 0;
	int      frames_sent = 0;
	int      cfg_writes = 0;
	int      idle_cycles = 0;
	bit      calm = 1'b0;

	function automatic void clear_parse();
		pos = '0;
		fcw = '0;
		sig_ok = 1'b0;
		src_addr = '0;
		next_ie = 12'(IE_START);
		ie_phase = IE_AWAIT_ID;
		ie_len = '0;
		ssid_st = SSID_SEARCH;
		ssid_at = '0;
		ssid_cnt = '0;
	endfunction

	function automatic int addr_offset();
		return (fcw[3:2] == TYPE_CTRL && fcw[7:4] >= SUB_CF_END) ? ADDR_OFF_CFEND
			: ADDR_OFF_STD;
	endfunction

	function automatic kind_t frame_class();
		logic [1:0] t;
		logic [3:0] s;
		t = fcw[3:2];
		s = fcw[7:4];
		if (!sig_ok)
			return KIND_IGNORED;
		if (t == TYPE_MGMT) begin
			if (s == SUB_ASSOC_REQ || s == SUB_REASSOC_REQ)
				return KIND_ASSOC;
			if (s == SUB_PROBE_REQ)
				return KIND_PROBE;
			if (s == SUB_DISASSOC || s == SUB_DEAUTH)
				return KIND_DEAUTH;
			return KIND_IGNORED;
		end
		if (mgmt_only_mode)
			return KIND_IGNORED;
		if (t == TYPE_CTRL)
			return ((s >= SUB_CTRL_LO && s <= SUB_CTRL_HI) || s >= SUB_CTRL_TOP)
				? KIND_CONTROL : KIND_IGNORED;
		if (t == TYPE_DATA)
			return KIND_DATA;
		return KIND_IGNORED;
	endfunction

	// element walk of a probe request, looking for the ssid element
	function automatic void walk_element(int i, logic [7:0] b);
		int nxt;
		if (ssid_st == SSID_SEARCH) begin
			case (ie_phase)
				IE_AWAIT_ID: begin
					if (i == next_ie)
						ie_phase = (b == IE_ID_SSID) ? IE_AWAIT_SSID_LEN : IE_AWAIT_LEN;
				end
				IE_AWAIT_LEN: begin
					ie_len = b;
					nxt = int'(next_ie) + 2 + int'(b);
					next_ie = (nxt > MAX_FRAME) ? 12'(MAX_FRAME) : 12'(nxt);
					ie_phase = IE_AWAIT_ID;
				end
				default: begin
					ie_len = b;
					ie_phase = IE_AWAIT_ID;
					if (b == 8'd0) begin
						ssid_st = SSID_HIDDEN;
					end else begin
						ssid_cnt = (b > SSID_MAX) ? 6'(SSID_MAX) : 6'(b);
						ssid_at = 12'(i + 1);
						ssid_st = SSID_FOUND;
					end
				end
			endcase
		end else if (ssid_st == SSID_FOUND) begin
			if (i >= int'(ssid_at) && i < int'(ssid_at) + int'(ssid_cnt))
				ssid_mem[i - int'(ssid_at)] = (b >= PRINT_LO && b <= PRINT_HI) ? b : DOT_CHAR;
		end
	endfunction

	// one accepted byte; on the last byte of a frame queue its result beats
	function automatic void parse_frame_byte(logic [7:0] b, bit first, bit last,
			logic signed [7:0] level, bit pin, kind_t pinned);
		int      i;
		int      len;
		int      nchars;
		int      k;
		kind_t   kind;
		logic    ok;
		logic [47:0] addr;
		result_t r;
		if (first) begin
			clear_parse();
			sig_ok = (level >= rssi_floor);
		end
		if (pos < MAX_FRAME) begin
			i = int'(pos);
			if (i == 0)
				fcw[7:0] = b;
			else if (i == 1)
				fcw[15:8] = b;
			if (i >= addr_offset() && i < addr_offset() + ADDR_BYTES)
				src_addr[8*(i - addr_offset()) +: 8] = b;
			if (fcw[3:2] == TYPE_MGMT && fcw[7:4] == SUB_PROBE_REQ)
				walk_element(i, b);
			pos = pos + 12'd1;
		end
		if (!last)
			return;
		len = int'(pos);
		kind = frame_class();
		ok = (kind != KIND_IGNORED && len >= addr_offset() + ADDR_BYTES);
		addr = ok ? src_addr : '0;
		nchars = 0;
		if (kind == KIND_PROBE && ssid_st == SSID_FOUND
				&& int'(ssid_at) + int'(ssid_cnt) <= len)
			nchars = int'(ssid_cnt);
		for (k = 0; k <= nchars; k++) begin
			r.kind = pin ? pinned : kind;
			r.addr = addr;
			r.valid = ok;
			r.ch = (k == 0) ? 8'd0 : ssid_mem[k - 1];
			r.is_char = (k != 0);
			r.last = (k == nchars);
			expected_beats.push_back(r);
			beats_predicted++;
		end
		clear_parse();
	endfunction

	function automatic byte_q_t head_bytes(logic [7:0] fc0, int n);
		byte_q_t q;
		q.push_back(fc0);
		repeat (n - 1) q.push_back(8'($urandom));
		return q;
	endfunction

	// probe request: header, some other elements, then the ssid element
	function automatic byte_q_t probe_bytes(int ssid_len, int others, int extra);
		byte_q_t q;
		int      n;
		q = head_bytes({SUB_PROBE_REQ, TYPE_MGMT, 2'($urandom)}, IE_START);
		repeat (others) begin
			n = $urandom_range(0, 8);
			q.push_back(8'($urandom_range(1, 255)));
			q.push_back(8'(n));
			repeat (n) q.push_back(8'($urandom));
		end
		if (ssid_len >= 0) begin
			q.push_back(IE_ID_SSID);
			q.push_back(8'(ssid_len));
			repeat ((ssid_len > SSID_MAX ? SSID_MAX : ssid_len) + extra) begin
				// mostly printable, some bytes that must turn into dots
				if ($urandom_range(0, 3) == 0)
					q.push_back(8'($urandom));
				else
					q.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
			end
		end else begin
			repeat (extra) q.push_back(8'($urandom));
		end
		return q;
	endfunction

	task automatic push_byte(logic [7:0] b, bit first, bit last, logic signed [7:0] level,
			bit pin, kind_t pinned);
		push <= 1'b1;
		frame_byte <= b;
		first_of_frame <= first;
		last_of_frame <= last;
		signal_level <= level;
		do @(posedge clk); while (full);
		parse_frame_byte(b, first, last, level, pin, pinned);
		bytes_sent++;
	endtask

	task automatic send_frame(byte_q_t q, logic signed [7:0] level, bit marked, bit pin,
			kind_t pinned, bit closed);
		bit                gappy;
		int                n;
		logic signed [7:0] lv;
		gappy = ($urandom_range(0, 2) != 0);
		for (n = 0; n < q.size(); n++) begin
			if (gappy && !calm && $urandom_range(0, 7) == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			// level only matters with the first byte, the rest is noise
			lv = (n == 0) ? level : 8'($urandom);
			push_byte(q[n], marked && n == 0, closed && n == q.size() - 1, lv, pin, pinned);
		end
		if (closed)
			frames_sent++;
	endtask

	task automatic settle();
		push <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] index, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (index == CFG_MIN_RSSI)
			rssi_floor = data;
		else if (index == CFG_MGMT_ONLY)
			mgmt_only_mode = data[0];
		cfg_writes++;
	endtask

	task automatic apply_settings(logic signed [7:0] rssi, bit mgmt, bit every);
		if (!every && rssi == rssi_floor && mgmt == mgmt_only_mode)
			return;
		settle();
		if (every || rssi != rssi_floor)
			write_reg(CFG_MIN_RSSI, rssi);
		if (every || mgmt != mgmt_only_mode)
			write_reg(CFG_MGMT_ONLY, {7'd0, mgmt});
		cfg_valid <= 1'b0;
	endtask

	task automatic random_frame(logic signed [7:0] rssi);
		byte_q_t           q;
		int                pick;
		int                ssid_len;
		int                cut;
		logic signed [7:0] lv;
		bit                marked;
		pick = $urandom_range(0, 9);
		// bias the level to pass the threshold most of the time
		if ($urandom_range(0, 3) == 0)
			lv = 8'($urandom);
		else
			lv = 8'($urandom_range(int'(rssi) + 128, 255) - 128);
		marked = ($urandom_range(0, 19) != 0);
		if (pick == 9)
			send_frame(head_bytes(8'($urandom), $urandom_range(1, 20)), 8'($urandom), 1'b1,
				1'b0, KIND_IGNORED, 1'b0);
		if (pick <= 5 || (pick == 9 && $urandom_range(0, 1) == 0)) begin
			case ($urandom_range(0, 19))
				0, 1:    ssid_len = 0;
				16:      ssid_len = SSID_MAX;
				17:      ssid_len = -1;
				18, 19:  ssid_len = $urandom_range(SSID_MAX + 1, 255);
				default: ssid_len = $urandom_range(1, 12);
			endcase
			q = probe_bytes(ssid_len, $urandom_range(0, 2), $urandom_range(0, 3));
			if ($urandom_range(0, 6) == 0) begin
				cut = $urandom_range(1, q.size());
				while (q.size() > cut) void'(q.pop_back());
			end
		end else if (pick == 8) begin
			q = head_bytes(8'($urandom), $urandom_range(1, 30));
			marked = $urandom_range(0, 1);
		end else begin
			q = head_bytes(8'($urandom), $urandom_range(1, 40));
		end
		send_frame(q, lv, marked, 1'b0, KIND_IGNORED, 1'b1);
	endtask

	function automatic void check_field(string what, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// result side
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: result beat with nothing pending, kind %0d char %h",
					$time, frame_kind, ssid_char);
				mismatches++;
			end else begin
				check_field("frame_kind", 48'(expected_beats[0].kind), 48'(frame_kind));
				check_field("source_address", expected_beats[0].addr, source_address);
				check_field("address_valid", 48'(expected_beats[0].valid), 48'(address_valid));
				check_field("ssid_char", 48'(expected_beats[0].ch), 48'(ssid_char));
				check_field("is_ssid_char", 48'(expected_beats[0].is_char),
					48'(is_ssid_char));
				check_field("last_result", 48'(expected_beats[0].last), 48'(last_result));
				void'(expected_beats.pop_front());
				beats_checked++;
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		frame_row_t        fr;
		byte_q_t           q;
		int                row;
		int                rand_bytes0;
		int                rand_beats0;
		logic signed [7:0] rssi_pick;
		bit                mgmt_pick;
		clear_parse();
		rssi_floor = RSSI_RESET;
		mgmt_only_mode = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < PLAN_ROWS; row++) begin
			fr = FRAME_PLAN[row];
			apply_settings(fr.rssi, fr.mgmt, row == 0);
			if (fr.lead != 0)
				send_frame(head_bytes(fr.fc0, fr.lead), fr.level, 1'b1, 1'b0, KIND_IGNORED,
					1'b0);
			if (fr.fc0[3:2] == TYPE_MGMT && fr.fc0[7:4] == SUB_PROBE_REQ) begin
				q = probe_bytes(fr.ssid, fr.others, 2);
				q[0] = fr.fc0;
			end else begin
				q = head_bytes(fr.fc0, fr.nbytes);
			end
			if (fr.nbytes != 0) begin
				while (q.size() > fr.nbytes) void'(q.pop_back());
				while (q.size() < fr.nbytes) q.push_back(8'($urandom));
			end
			send_frame(q, fr.level, fr.marked, fr.pin, fr.kind, 1'b1);
		end

		rand_bytes0 = bytes_sent;
		rand_beats0 = beats_predicted;
		while (bytes_sent - rand_bytes0 < RANDOM_BYTES
				|| beats_predicted - rand_beats0 < RANDOM_BEATS) begin
			case ($urandom_range(0, 4))
				0:       rssi_pick = 8'sh80;
				1:       rssi_pick = 8'sd127;
				2:       rssi_pick = RSSI_RESET;
				default: rssi_pick = 8'($urandom);
			endcase
			mgmt_pick = $urandom_range(0, 1);
			apply_settings(rssi_pick, mgmt_pick, 1'b0);
			repeat (6) random_frame(rssi_pick);
			if (bytes_sent - rand_bytes0 >= CALM_AFTER)
				calm = 1'b1;
		end

		settle();
		repeat (20) @(posedge clk);
		$display("covered %0d frames, %0d bytes, %0d register writes", frames_sent,
			bytes_sent, cfg_writes);
		$display("checked %0d result beats, %0d mismatches", beats_checked, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
